// ----- hdl/cpn_pkg.sv -----
// Package for the connection phase and packet number block.
// Holds phase, event and space codes, the phase encoding and the stage structs.
// No dependencies.
package cpn_pkg;

    localparam int NUM_SPACES = 3;
    localparam int PN_W       = 64;

    localparam logic FUNC_EVENT = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    localparam logic [2:0] EV_PROGRESS  = 3'd0;
    localparam logic [2:0] EV_CONFIRMED = 3'd1;
    localparam logic [2:0] EV_CLOSE     = 3'd2;
    localparam logic [2:0] EV_DRAIN     = 3'd3;
    localparam logic [2:0] EV_CLOSED    = 3'd4;

    localparam logic [2:0] PH_INITIAL   = 3'd0;
    localparam logic [2:0] PH_HANDSHAKE = 3'd1;
    localparam logic [2:0] PH_CONFIRMED = 3'd2;
    localparam logic [2:0] PH_CLOSING   = 3'd3;
    localparam logic [2:0] PH_DRAINING  = 3'd4;
    localparam logic [2:0] PH_CLOSED    = 3'd5;

    localparam logic [1:0] SPACE_APP = 2'd2;

    typedef enum logic [5:0] {
        S_INITIAL   = 6'b000001,
        S_HANDSHAKE = 6'b000010,
        S_CONFIRMED = 6'b000100,
        S_CLOSING   = 6'b001000,
        S_DRAINING  = 6'b010000,
        S_CLOSED    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic       func;
        logic [2:0] event_req;
        logic [1:0] space;
    } t_cpn_req;

    typedef struct packed {
        logic            ok;
        logic [2:0]      phase_now;
        logic [PN_W-1:0] packet_number;
    } t_cpn_rsp;

    function automatic logic [2:0] phase_code(t_phase p);
        logic [2:0] c;
        case (p)
            S_INITIAL:   c = PH_INITIAL;
            S_HANDSHAKE: c = PH_HANDSHAKE;
            S_CONFIRMED: c = PH_CONFIRMED;
            S_CLOSING:   c = PH_CLOSING;
            S_DRAINING:  c = PH_DRAINING;
            S_CLOSED:    c = PH_CLOSED;
            default:     c = PH_INITIAL;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/cpn_ifs.sv -----
// Valid/ready channel interfaces for request and response items.
// Depends on cpn_pkg.
interface cpn_in_if import cpn_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       func;
    logic [2:0] event_req;
    logic [1:0] space;

    modport source (output valid, output func, output event_req, output space, input ready);
    modport sink   (input valid, input func, input event_req, input space, output ready);
endinterface

interface cpn_out_if import cpn_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            ok;
    logic [2:0]      phase_now;
    logic [PN_W-1:0] packet_number;

    modport source (output valid, output ok, output phase_now, output packet_number,
                    input ready);
    modport sink   (input valid, input ok, input phase_now, input packet_number,
                    output ready);
endinterface

// ----- hdl/connection_phase_and_packet_numbers.sv -----
// Top level: connection phase tracker with per-space packet number counters.
// Depends on cpn_pkg, cpn_ifs, cpn_in_reg, cpn_core, cpn_out_reg.
//
//   channel  dir  payload                                  handshake
//   i_req    in   func, event_req, space                   valid/ready
//   o_rsp    out  ok, phase_now, packet_number             valid/ready
//
// One item per cycle sustained while the output is not stalled.
// The item sits in the input register while the phase table and counter increment
// run; phase and counters update at the edge the result register loads.
// Reset (synchronous, active low) sets the initial phase and zeroes all counters.
// A stalled output holds its item; the input register still takes one more item.
module connection_phase_and_packet_numbers import cpn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cpn_in_if.sink    i_req,
    cpn_out_if.source o_rsp
);

    logic     w_in_valid;
    t_cpn_req w_req;
    t_cpn_rsp w_rsp;
    logic     w_can_load;
    logic     w_fire;

    assign w_fire = w_in_valid && w_can_load;

    cpn_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_req   (w_req)
    );

    cpn_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    cpn_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_rsp      (w_rsp),
        .o_can_load (w_can_load),
        .o_rsp      (o_rsp)
    );

endmodule

// ----- hdl/cpn_in_reg.sv -----
// Input register stage: captures one request item.
// Depends on cpn_pkg and cpn_in_if.
module cpn_in_reg import cpn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cpn_in_if.sink   i_req,
    input  logic     i_take,
    output logic     o_valid,
    output t_cpn_req o_req
);

    logic     r_valid;
    logic     n_valid;
    t_cpn_req r_req;
    logic     w_load;

    assign i_req.ready = !r_valid || i_take;
    assign w_load      = i_req.valid && i_req.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_req.func      <= i_req.func;
            r_req.event_req <= i_req.event_req;
            r_req.space     <= i_req.space;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// ----- hdl/cpn_core.sv -----
// Phase register, per-space packet number counters and the result logic.
// Depends on cpn_pkg.
module cpn_core import cpn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_cpn_req i_req,
    output t_cpn_rsp o_rsp
);

    t_phase          r_phase;
    t_phase          n_phase;
    logic [PN_W-1:0] r_cnt [NUM_SPACES];
    logic [PN_W-1:0] w_sel;
    logic            w_in_range;
    logic            w_grant;
    logic            w_ev_ok;
    t_phase          w_ev_phase;

    always_comb begin
        w_ev_ok    = 1'b0;
        w_ev_phase = r_phase;
        case (r_phase)
            S_INITIAL: begin
                if (i_req.event_req == EV_PROGRESS) begin
                    w_ev_ok = 1'b1; w_ev_phase = S_HANDSHAKE;
                end
            end
            S_HANDSHAKE: begin
                if (i_req.event_req == EV_CONFIRMED) begin
                    w_ev_ok = 1'b1; w_ev_phase = S_CONFIRMED;
                end
            end
            S_CLOSING, S_DRAINING: begin
                if (i_req.event_req == EV_CLOSED) begin
                    w_ev_ok = 1'b1; w_ev_phase = S_CLOSED;
                end
            end
            default: ;
        endcase
        if (r_phase == S_INITIAL || r_phase == S_HANDSHAKE || r_phase == S_CONFIRMED) begin
            if (i_req.event_req == EV_CLOSE) begin
                w_ev_ok = 1'b1; w_ev_phase = S_CLOSING;
            end else if (i_req.event_req == EV_DRAIN) begin
                w_ev_ok = 1'b1; w_ev_phase = S_DRAINING;
            end
        end
    end

    assign w_in_range = 32'(i_req.space) < 32'(NUM_SPACES);
    assign w_grant    = w_in_range && !(i_req.space == SPACE_APP && r_phase != S_CONFIRMED);

    always_comb begin
        w_sel = '0;
        for (int k = 0; k < NUM_SPACES; k++) begin
            if (32'(i_req.space) == k) begin
                w_sel = r_cnt[k];
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (i_fire && i_req.func == FUNC_EVENT && w_ev_ok) begin
            n_phase = w_ev_phase;
        end
    end

    always_comb begin
        if (i_req.func == FUNC_EVENT) begin
            o_rsp.ok            = w_ev_ok;
            o_rsp.phase_now     = phase_code(w_ev_phase);
            o_rsp.packet_number = '0;
        end else begin
            o_rsp.ok            = w_grant;
            o_rsp.phase_now     = phase_code(r_phase);
            o_rsp.packet_number = w_grant ? w_sel : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_INITIAL;
            for (int k = 0; k < NUM_SPACES; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            for (int k = 0; k < NUM_SPACES; k++) begin
                if (i_fire && i_req.func == FUNC_ALLOC && w_grant && 32'(i_req.space) == k) begin
                    r_cnt[k] <= r_cnt[k] + PN_W'(1);
                end
            end
        end
    end

    a_app_needs_confirmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.func == FUNC_ALLOC && i_req.space == SPACE_APP && o_rsp.ok)
        |-> (r_phase == S_CONFIRMED))
        else $error("application number granted outside confirmed phase");

    a_phase_moves_on_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_phase))
        |-> $past(i_fire && i_req.func == FUNC_EVENT && o_rsp.ok))
        else $error("phase changed without an accepted event");

    a_cnt0_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.func == FUNC_ALLOC && i_req.space == 2'd0)
        |=> (r_cnt[0] == $past(r_cnt[0]) + PN_W'(1)))
        else $error("initial space counter did not advance by one");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_rsp.ok) |-> (o_rsp.packet_number == '0))
        else $error("refused item carries a packet number");

endmodule

// ----- hdl/cpn_out_reg.sv -----
// Result register stage: holds one response item until it is taken.
// Depends on cpn_pkg and cpn_out_if.
module cpn_out_reg import cpn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_cpn_rsp i_rsp,
    output logic     o_can_load,
    cpn_out_if.source o_rsp
);

    logic     r_valid;
    logic     n_valid;
    t_cpn_rsp r_rsp;

    assign o_can_load = !r_valid || o_rsp.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.ok            = r_rsp.ok;
    assign o_rsp.phase_now     = r_rsp.phase_now;
    assign o_rsp.packet_number = r_rsp.packet_number;

endmodule

// ----- tb/cpn_checker.sv -----
// Checker for the connection phase and packet number block: watches both channels,
// predicts each result item from the accepted request items and compares field by field.
// Depends on cpn_pkg and cpn_ifs.
module cpn_checker import cpn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    cpn_in_if    i_req,
    cpn_out_if   i_rsp,
    output int   o_pending,
    output int   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0]      conn_phase;
    logic [PN_W-1:0] next_pn [NUM_SPACES];
    t_cpn_rsp        expected_rsp [$];

    function automatic t_cpn_rsp advance_connection(t_cpn_req r);
        t_cpn_rsp   e;
        logic [2:0] nxt;
        logic       open_phase;
        e          = '0;
        nxt        = conn_phase;
        open_phase = (conn_phase == PH_INITIAL) || (conn_phase == PH_HANDSHAKE) ||
                     (conn_phase == PH_CONFIRMED);
        if (r.func == FUNC_EVENT) begin
            case (r.event_req)
                EV_PROGRESS:  if (conn_phase == PH_INITIAL) nxt = PH_HANDSHAKE;
                EV_CONFIRMED: if (conn_phase == PH_HANDSHAKE) nxt = PH_CONFIRMED;
                EV_CLOSE:     if (open_phase) nxt = PH_CLOSING;
                EV_DRAIN:     if (open_phase) nxt = PH_DRAINING;
                EV_CLOSED: begin
                    if (conn_phase == PH_CLOSING || conn_phase == PH_DRAINING) nxt = PH_CLOSED;
                end
                default: ;
            endcase
            // every table row changes the phase
            e.ok       = (nxt != conn_phase);
            conn_phase = nxt;
        end else if (r.space < NUM_SPACES &&
                     (r.space != SPACE_APP || conn_phase == PH_CONFIRMED)) begin
            e.ok              = 1'b1;
            e.packet_number   = next_pn[r.space];
            next_pn[r.space]  = next_pn[r.space] + 1'b1;
        end
        e.phase_now = conn_phase;
        return e;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_cpn_req req;
        t_cpn_rsp exp_rsp;
        if (!i_rst_n) begin
            conn_phase = PH_INITIAL;
            foreach (next_pn[i]) next_pn[i] = '0;
            expected_rsp.delete();
            o_fail_count = 0;
            o_pending   <= 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_rsp.size() == 0) begin
                    $error("result item with no request pending");
                    o_fail_count++;
                end else begin
                    exp_rsp = expected_rsp.pop_front();
                    if (i_rsp.ok !== exp_rsp.ok) begin
                        $error("ok: expected %0d, got %0d", exp_rsp.ok, i_rsp.ok);
                        o_fail_count++;
                    end
                    if (i_rsp.phase_now !== exp_rsp.phase_now) begin
                        $error("phase_now: expected %0d, got %0d",
                               exp_rsp.phase_now, i_rsp.phase_now);
                        o_fail_count++;
                    end
                    if (i_rsp.packet_number !== exp_rsp.packet_number) begin
                        $error("packet_number: expected %0h, got %0h",
                               exp_rsp.packet_number, i_rsp.packet_number);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                req.func      = i_req.func;
                req.event_req = i_req.event_req;
                req.space     = i_req.space;
                expected_rsp.push_back(advance_connection(req));
            end
            o_pending <= expected_rsp.size();
        end
    end

endmodule

// ----- tb/connection_phase_and_packet_numbers_tb.sv -----
// Testbench top: clock, reset, request stimulus and response back-pressure for the
// connection phase and packet number block; the verdict comes from cpn_checker.
// Depends on cpn_pkg, cpn_ifs, cpn_checker and the block itself.
module connection_phase_and_packet_numbers_tb import cpn_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM     = 1000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   idle_pct = 23;
    int   pending;
    int   fail_count;
    int   cycle_count = 0;

    cpn_in_if  req_if ();
    cpn_out_if rsp_if ();

    connection_phase_and_packet_numbers u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    cpn_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input logic f, input logic [2:0] ev, input logic [1:0] sp);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= f;
        req_if.event_req <= ev;
        req_if.space     <= sp;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic send_event(input logic [2:0] ev);
        send_item(FUNC_EVENT, ev, 2'($urandom_range(3)));
    endtask

    task automatic send_alloc(input logic [1:0] sp);
        send_item(FUNC_ALLOC, 3'($urandom_range(7)), sp);
    endtask

    task automatic wait_all_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [2:0] ev;
        req_if.valid     <= 1'b0;
        req_if.func      <= FUNC_EVENT;
        req_if.event_req <= EV_PROGRESS;
        req_if.space     <= '0;
        i_rst_n          <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // initial phase: spaces, unknown codes, events with no row
        send_alloc(2'd0);
        send_alloc(2'd1);
        send_alloc(SPACE_APP);
        send_alloc(2'd3);
        send_event(3'd5);
        send_event(3'd6);
        send_event(3'd7);
        send_event(EV_CONFIRMED);
        send_event(EV_CLOSED);
        send_alloc(2'd0);
        // handshake phase
        send_event(EV_PROGRESS);
        send_event(EV_PROGRESS);
        send_alloc(SPACE_APP);
        send_alloc(2'd1);
        send_event(EV_CLOSED);
        // confirmed phase: application space opens
        send_event(EV_CONFIRMED);
        send_alloc(SPACE_APP);
        send_alloc(SPACE_APP);
        send_alloc(2'd3);
        send_event(EV_CONFIRMED);
        send_event(EV_CLOSED);

        // mostly allocations; close and drain kept rare so the open phases last
        for (int i = 0; i < N_RANDOM; i++) begin
            idle_pct = (i >= 300 && i < 500) ? 0 : 23;
            if (i == 700) wait_all_results();
            if ($urandom_range(99) < 75) begin
                send_alloc(2'($urandom_range(3)));
            end else begin
                ev = 3'($urandom_range(7));
                if ((ev == EV_CLOSE || ev == EV_DRAIN) && $urandom_range(7) != 0) begin
                    ev = $urandom_range(1) ? EV_CONFIRMED : EV_PROGRESS;
                end
                send_event(ev);
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/cpn_pkg.sv
hdl/cpn_ifs.sv
hdl/cpn_in_reg.sv
hdl/cpn_core.sv
hdl/cpn_out_reg.sv
hdl/connection_phase_and_packet_numbers.sv
tb/cpn_checker.sv
tb/connection_phase_and_packet_numbers_tb.sv
